[hw/rtl/lri_pkg.sv]
`timescale 1ns / 1ps
package lri_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRAC_BITS     = 16;
   localparam int CFG_WIDTH     = 32;
   localparam int ACC_WIDTH     = 64;
   localparam int ELAPSED_WIDTH = 56;
   localparam int MUL_WIDTH     = (VALUE_WIDTH > CFG_WIDTH) ? VALUE_WIDTH : CFG_WIDTH;
   localparam int DIV_NUM_WIDTH = ACC_WIDTH + 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int MODE_WIDTH    = 5;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIME_STEP = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODE      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INITIAL   = 3'd5;

   // mode bits
   localparam int MODE_LOWER = 0;
   localparam int MODE_UPPER = 1;
   localparam int MODE_AVG   = 2;
   localparam int MODE_SQIN  = 3;
   localparam int MODE_SQRT  = 4;

   localparam logic [CFG_WIDTH-1:0]  GAIN_RESET      = 32'd65536;
   localparam logic [CFG_WIDTH-1:0]  TIME_STEP_RESET = 32'd16777;
   localparam logic [CFG_WIDTH-1:0]  LOWER_RESET     = 32'd0;
   localparam logic [CFG_WIDTH-1:0]  UPPER_RESET     = 32'd65536;
   localparam logic [MODE_WIDTH-1:0] MODE_RESET      = 5'd0;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sample_plus;
      logic signed [VALUE_WIDTH-1:0] sample_minus;
      logic signed [VALUE_WIDTH-1:0] sample_extra;
      logic                          restart;
      logic signed [VALUE_WIDTH-1:0] restart_value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] result_value;
      logic [62:0]                   result_squared;
      logic                          saturated;
   } rsp_word_type;

endpackage

[hw/rtl/lri_smul.sv]
`timescale 1ns / 1ps
module lri_smul #(
   parameter int W = lri_pkg::MUL_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           busy,
   output logic [2*W-1:0] prod
);
   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] prod_ff;
   logic [W-1:0]   a_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic [W:0]     sum;

   // shift-add, one multiplier bit per cycle
   assign sum = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a;
         prod_ff <= {{W{1'b0}}, b};
      end else if (busy_ff) begin
         prod_ff <= {sum, prod_ff[W-1:1]};
      end
   end

   assign busy = busy_ff;
   assign prod = prod_ff;
endmodule

[hw/rtl/lri_sdiv.sv]
`timescale 1ns / 1ps
module lri_sdiv #(
   parameter int NW = lri_pkg::DIV_NUM_WIDTH,
   parameter int DW = lri_pkg::ELAPSED_WIDTH,
   parameter int QW = lri_pkg::VALUE_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [QW-1:0] quot,
   output logic          ovf
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] q_ff;
   logic          ovf_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [DW:0]   r;
   logic          ge;

   // restoring division, one quotient bit per cycle
   assign r  = {rem_ff, num_ff[NW-1]};
   assign ge = r >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NW-2:0], 1'b0};
         rem_ff <= ge ? DW'(r - {1'b0, den_ff}) : DW'(r);
         q_ff   <= {q_ff[QW-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[QW-1];
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign ovf  = ovf_ff;
endmodule

[hw/rtl/limited_resettable_integrator_top.sv]
`timescale 1ns / 1ps
// Sequence: three 32-bit shift-add multiplies (gain, time step, output square)
// around the accumulate and select steps. The input square adds a multiply,
// averaging adds a 72-bit serial divide and the square root adds a serial
// root stage.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is registered, and the result waits while the receiver stalls the last one.
// Reset (synchronous): registers to defaults, accumulator and elapsed time 0.
module limited_resettable_integrator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lri_pkg::req_word_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lri_pkg::rsp_word_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [lri_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lri_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   localparam int VW  = lri_pkg::VALUE_WIDTH;
   localparam int MW  = lri_pkg::MUL_WIDTH;
   localparam int PW  = 2 * MW;
   localparam int AW  = lri_pkg::ACC_WIDTH;
   localparam int EW  = lri_pkg::ELAPSED_WIDTH;
   localparam int IQW = (PW - 7 > 65) ? PW - 7 : 65;
   localparam int SW  = 2 * ((VW + 17) / 2);
   localparam int RW  = SW / 2;
   localparam int SCW = $clog2(RW + 1);

   localparam logic [VW-1:0] VMAX_U = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMIN_U = {1'b1, {(VW-1){1'b0}}};
   localparam logic [AW-1:0] VMAX64 = AW'(VMAX_U);
   localparam logic [AW-1:0] VMIN64 = ~VMAX64;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQ     = 4'd1;
   localparam logic [3:0] ST_GAIN   = 4'd2;
   localparam logic [3:0] ST_INC    = 4'd3;
   localparam logic [3:0] ST_ACC    = 4'd4;
   localparam logic [3:0] ST_PICK   = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_ROOT   = 4'd7;
   localparam logic [3:0] ST_SQRT   = 4'd8;
   localparam logic [3:0] ST_MSTART = 4'd9;
   localparam logic [3:0] ST_SQO    = 4'd10;

   function automatic logic [MW-1:0] val_mag(input logic [VW-1:0] v);
      logic [VW-1:0] m;
      m = v[VW-1] ? VW'(~v + 1'b1) : v;
      return MW'(m);
   endfunction

   // floor(p / 2^16) with sign, saturated to the value range; returns {sat, value}
   function automatic logic [VW:0] post_val(input logic [PW-1:0] p, input logic neg);
      logic [PW-16:0] q;
      logic           rnd;
      rnd = neg && (p[15:0] != '0);
      q = {1'b0, p[PW-1:16]} + (PW-15)'(rnd);
      if (!neg) begin
         if (q > (PW-15)'(VMAX_U)) return {1'b1, VMAX_U};
         return {1'b0, q[VW-1:0]};
      end
      if (q > (PW-15)'(VMIN_U)) return {1'b1, VMIN_U};
      return {1'b0, VW'(~q[VW-1:0] + 1'b1)};
   endfunction

   logic [lri_pkg::CFG_WIDTH-1:0]  gain_ff, gain_in, tstep_ff, tstep_in;
   logic [lri_pkg::CFG_WIDTH-1:0]  lower_ff, lower_in, upper_ff, upper_in;
   logic [lri_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [EW-1:0] elapsed_ff, elapsed_in;
   logic [3:0]    state_ff, state_in;
   logic [VW-1:0] sval_ff, sval_in, term_ff, term_in, outv_ff, outv_in, rval_ff, rval_in;
   logic          restart_ff, restart_in, sat_ff, sat_in;
   logic [AW-1:0] inc_ff, inc_in;
   logic [SW-1:0] x_ff, x_in;
   logic [RW+1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [SCW-1:0] scnt_ff, scnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lri_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic          mul_start, mul_busy;
   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] mul_prod;
   logic          div_start, div_busy, div_ovf;
   logic [VW-1:0] div_quot;

   logic                 req_accept;
   logic signed [VW+1:0] ssum;
   logic [VW-1:0]        sclamp;
   logic                 ssat;
   logic [VW:0]          pv;
   logic [IQW-1:0]       iq;
   logic [AW-1:0]        base;
   logic [AW:0]          asum;
   logic [AW-1:0]        anew, lim;
   logic [EW:0]          esum;
   logic [AW-1:0]        ash, amag;
   logic [RW+3:0]        sq_r, sq_t;
   logic                 sq_ge;
   logic [RW-1:0]        root_nx;
   logic [PW-64:0]       sq_hi;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;

   assign ssum = (VW+2)'(req_data.sample_plus) - (VW+2)'(req_data.sample_minus)
               + (VW+2)'(req_data.sample_extra);
   always_comb begin
      ssat = 1'b1;
      if (ssum > $signed((VW+2)'(VMAX_U)))
         sclamp = VMAX_U;
      else if (ssum < $signed(~(VW+2)'(VMAX_U)))
         sclamp = VMIN_U;
      else begin
         sclamp = ssum[VW-1:0];
         ssat = 1'b0;
      end
   end

   assign sq_r    = {rem_ff, x_ff[SW-1 -: 2]};
   assign sq_t    = {2'b00, root_ff, 2'b01};
   assign sq_ge   = sq_r >= sq_t;
   assign root_nx = {root_ff[RW-2:0], sq_ge};
   assign amag    = acc_ff[AW-1] ? AW'(~acc_ff + 1'b1) : acc_ff;
   assign ash     = AW'($signed(acc_ff) >>> lri_pkg::FRAC_BITS);
   assign sq_hi   = mul_prod[PW-1:63];

   always_comb begin
      gain_in = gain_ff; tstep_in = tstep_ff; lower_in = lower_ff; upper_in = upper_ff;
      mode_in = mode_ff; acc_in = acc_ff; elapsed_in = elapsed_ff;
      state_in = state_ff; sval_in = sval_ff; term_in = term_ff; outv_in = outv_ff;
      rval_in = rval_ff; restart_in = restart_ff; sat_in = sat_ff; inc_in = inc_ff;
      x_in = x_ff; rem_in = rem_ff; root_in = root_ff; scnt_in = scnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start = 1'b0; mul_a = '0; mul_b = '0; div_start = 1'b0;
      pv = '0; iq = '0; base = '0; asum = '0; anew = '0; lim = '0; esum = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sval_in    = sclamp;
               sat_in     = ssat;
               restart_in = req_data.restart;
               rval_in    = req_data.restart_value;
               mul_start  = 1'b1;
               mul_a      = val_mag(sclamp);
               if (mode_ff[lri_pkg::MODE_SQIN]) begin
                  mul_b    = val_mag(sclamp);
                  state_in = ST_SQ;
               end else begin
                  mul_b    = MW'(gain_ff[31] ? ~gain_ff + 1'b1 : gain_ff);
                  state_in = ST_GAIN;
               end
            end
         end
         ST_SQ: begin
            if (!mul_busy) begin
               pv        = post_val(mul_prod, 1'b0);
               sval_in   = pv[VW-1:0];
               sat_in    = sat_ff | pv[VW];
               mul_start = 1'b1;
               mul_a     = MW'(pv[VW-1:0]);
               mul_b     = MW'(gain_ff[31] ? ~gain_ff + 1'b1 : gain_ff);
               state_in  = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (!mul_busy) begin
               pv        = post_val(mul_prod, sval_ff[VW-1] ^ gain_ff[31]);
               term_in   = pv[VW-1:0];
               sat_in    = sat_ff | pv[VW];
               mul_start = 1'b1;
               mul_a     = val_mag(pv[VW-1:0]);
               mul_b     = MW'(tstep_ff);
               state_in  = ST_INC;
            end
         end
         ST_INC: begin
            if (!mul_busy) begin
               // product shifted by 8 with floor rounding, 64-bit range
               iq = IQW'({1'b0, mul_prod[PW-1:8]})
                  + IQW'(term_ff[VW-1] && (mul_prod[7:0] != '0));
               if (!term_ff[VW-1]) begin
                  if (iq[IQW-1:63] != '0) begin
                     inc_in = {1'b0, {(AW-1){1'b1}}};
                     sat_in = 1'b1;
                  end else inc_in = iq[AW-1:0];
               end else begin
                  if (iq[IQW-1:64] != '0 || (iq[63] && iq[62:0] != '0)) begin
                     inc_in = {1'b1, {(AW-1){1'b0}}};
                     sat_in = 1'b1;
                  end else inc_in = AW'(~iq[AW-1:0] + 1'b1);
               end
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            base = restart_ff ? (AW'($signed(rval_ff)) << lri_pkg::FRAC_BITS) : acc_ff;
            asum = {base[AW-1], base} + {inc_ff[AW-1], inc_ff};
            if (asum[AW] != asum[AW-1]) begin
               anew   = asum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
               sat_in = 1'b1;
            end else anew = asum[AW-1:0];
            if (mode_ff[lri_pkg::MODE_LOWER]) begin
               lim = AW'($signed(lower_ff)) << lri_pkg::FRAC_BITS;
               if ($signed(anew) < $signed(lim)) anew = lim;
            end
            if (mode_ff[lri_pkg::MODE_UPPER]) begin
               lim = AW'($signed(upper_ff)) << lri_pkg::FRAC_BITS;
               if ($signed(anew) > $signed(lim)) anew = lim;
            end
            acc_in = anew;
            esum = (EW+1)'(restart_ff ? EW'(0) : elapsed_ff) + (EW+1)'(tstep_ff);
            if (esum[EW]) begin
               elapsed_in = '1;
               sat_in     = 1'b1;
            end else elapsed_in = esum[EW-1:0];
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (mode_ff[lri_pkg::MODE_AVG]) begin
               if (elapsed_ff == '0) begin
                  // zero elapsed time: range end by sign
                  if (acc_ff == '0) outv_in = '0;
                  else begin
                     outv_in = acc_ff[AW-1] ? VMIN_U : VMAX_U;
                     sat_in  = 1'b1;
                  end
                  state_in = ST_ROOT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               if ($signed(ash) > $signed(VMAX64)) begin
                  outv_in = VMAX_U;
                  sat_in  = 1'b1;
               end else if ($signed(ash) < $signed(VMIN64)) begin
                  outv_in = VMIN_U;
                  sat_in  = 1'b1;
               end else outv_in = ash[VW-1:0];
               state_in = ST_ROOT;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               if (!acc_ff[AW-1]) begin
                  if (div_ovf || div_quot > VMAX_U) begin
                     outv_in = VMAX_U;
                     sat_in  = 1'b1;
                  end else outv_in = div_quot;
               end else begin
                  if (div_ovf || div_quot > VMIN_U) begin
                     outv_in = VMIN_U;
                     sat_in  = 1'b1;
                  end else outv_in = VW'(~div_quot + 1'b1);
               end
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (mode_ff[lri_pkg::MODE_SQRT] && outv_ff[VW-1]) begin
               outv_in  = '0;
               state_in = ST_MSTART;
            end else if (mode_ff[lri_pkg::MODE_SQRT]) begin
               x_in     = SW'({outv_ff, {lri_pkg::FRAC_BITS{1'b0}}});
               rem_in   = '0;
               root_in  = '0;
               scnt_in  = SCW'(RW);
               state_in = ST_SQRT;
            end else state_in = ST_MSTART;
         end
         ST_SQRT: begin
            // two radicand bits per cycle
            x_in    = {x_ff[SW-3:0], 2'b00};
            rem_in  = sq_ge ? (RW+2)'(sq_r - sq_t) : (RW+2)'(sq_r);
            root_in = root_nx;
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == SCW'(1)) begin
               if ((VW+RW)'(root_nx) > (VW+RW)'(VMAX_U)) begin
                  outv_in = VMAX_U;
                  sat_in  = 1'b1;
               end else outv_in = VW'(root_nx);
               state_in = ST_MSTART;
            end
         end
         ST_MSTART: begin
            mul_start = 1'b1;
            mul_a     = val_mag(outv_ff);
            mul_b     = val_mag(outv_ff);
            state_in  = ST_SQO;
         end
         ST_SQO: begin
            if (!mul_busy && !(rsp_valid_ff && rsp_stall)) begin
               rsp_data_in.result_value = outv_ff;
               if (sq_hi != '0) begin
                  rsp_data_in.result_squared = '1;
                  rsp_data_in.saturated      = 1'b1;
               end else begin
                  rsp_data_in.result_squared = mul_prod[62:0];
                  rsp_data_in.saturated      = sat_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            lri_pkg::REG_GAIN:      gain_in  = csr_wdata;
            lri_pkg::REG_TIME_STEP: tstep_in = csr_wdata;
            lri_pkg::REG_LOWER:     lower_in = csr_wdata;
            lri_pkg::REG_UPPER:     upper_in = csr_wdata;
            lri_pkg::REG_MODE:      mode_in  = csr_wdata[lri_pkg::MODE_WIDTH-1:0];
            lri_pkg::REG_INITIAL: begin
               acc_in     = AW'($signed(csr_wdata)) << lri_pkg::FRAC_BITS;
               elapsed_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= lri_pkg::GAIN_RESET;
         tstep_ff     <= lri_pkg::TIME_STEP_RESET;
         lower_ff     <= lri_pkg::LOWER_RESET;
         upper_ff     <= lri_pkg::UPPER_RESET;
         mode_ff      <= lri_pkg::MODE_RESET;
         acc_ff       <= '0;
         elapsed_ff   <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         tstep_ff     <= tstep_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         elapsed_ff   <= elapsed_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sval_ff     <= sval_in;
      term_ff     <= term_in;
      outv_ff     <= outv_in;
      rval_ff     <= rval_in;
      restart_ff  <= restart_in;
      sat_ff      <= sat_in;
      inc_ff      <= inc_in;
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      scnt_ff     <= scnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   lri_smul #(.W(MW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod)
   );

   lri_sdiv #(.NW(lri_pkg::DIV_NUM_WIDTH), .DW(EW), .QW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({amag, 8'h00}),
      .divisor  (elapsed_ff),
      .busy     (div_busy),
      .quot     (div_quot),
      .ovf      (div_ovf)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier restarted while busy");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (elapsed_ff != '0))
      else $error("divide started with zero elapsed time");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SQO)
      else $error("result word raised outside final state");
`endif
endmodule

[tb/tb_limited_resettable_integrator_top.sv]
`timescale 1ns / 1ps
module tb_limited_resettable_integrator_top;

   localparam logic signed [63:0] VMAX = 64'sd2147483647;
   localparam logic signed [63:0] VMIN = -64'sd2147483648;
   localparam logic signed [63:0] AMAX = 64'h7fffffffffffffff;
   localparam logic signed [63:0] AMIN = 64'h8000000000000000;
   localparam logic [55:0] EMAX = {56{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lri_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lri_pkg::rsp_word_type rsp_data;
   logic csr_we = 1'b0;
   logic [lri_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [lri_pkg::CFG_WIDTH-1:0] csr_wdata = '0;

   limited_resettable_integrator_top u_dut (.*);

   always #2 clock = ~clock;

   // predictor copy of registers and state
   logic signed [31:0] m_gain = 32'sd65536;
   logic [31:0] m_step = 32'd16777;
   logic signed [31:0] m_lower = 0, m_upper = 32'sd65536, m_init = 0;
   logic [4:0] m_mode = 0;
   logic signed [63:0] m_acc = 0;
   logic [55:0] m_elapsed = 0;

   lri_pkg::rsp_word_type expected_q[$];
   int mismatches = 0, checked = 0, sent = 0, n_sat = 0;
   bit quiet = 0;

   // floor(a*b/2^k) clamped to [lo,hi]
   function automatic logic signed [63:0] mul_floor(logic signed [63:0] a,
         logic signed [63:0] b, int k, logic signed [63:0] lo,
         logic signed [63:0] hi, inout bit sat);
      logic signed [127:0] p, q;
      p = 128'(a) * 128'(b);
      q = p >>> k;
      if (q > 128'(hi)) begin sat = 1; return hi; end
      if (q < 128'(lo)) begin sat = 1; return lo; end
      return q[63:0];
   endfunction

   function automatic logic signed [63:0] clamp_value(logic signed [63:0] x, inout bit sat);
      if (x > VMAX) begin sat = 1; return VMAX; end
      if (x < VMIN) begin sat = 1; return VMIN; end
      return x;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((128'(r | (64'd1 << b)) * 128'(r | (64'd1 << b))) <= 128'(x)) r |= 64'd1 << b;
      return r;
   endfunction

   function automatic lri_pkg::rsp_word_type integrate_tick(lri_pkg::req_word_type w);
      bit sat;
      logic signed [63:0] s, term, inc, outv, lim;
      logic signed [64:0] wide;
      logic signed [127:0] num, quo;
      logic [56:0] el;
      logic [127:0] sq;
      lri_pkg::rsp_word_type r;
      sat = 0;
      s = 64'(w.sample_plus) - 64'(w.sample_minus) + 64'(w.sample_extra);
      s = clamp_value(s, sat);
      if (m_mode[lri_pkg::MODE_SQIN]) s = mul_floor(s, s, 16, VMIN, VMAX, sat);
      term = mul_floor(s, 64'(m_gain), 16, VMIN, VMAX, sat);
      if (w.restart) begin
         m_acc = 64'(w.restart_value) <<< 16;
         m_elapsed = 0;
      end
      inc = mul_floor(term, $signed({32'd0, m_step}), 8, AMIN, AMAX, sat);
      wide = 65'(m_acc) + 65'(inc);
      if (wide > 65'(AMAX)) begin m_acc = AMAX; sat = 1; end
      else if (wide < 65'(AMIN)) begin m_acc = AMIN; sat = 1; end
      else m_acc = wide[63:0];
      if (m_mode[lri_pkg::MODE_LOWER]) begin
         lim = 64'(m_lower) <<< 16;
         if (m_acc < lim) m_acc = lim;
      end
      if (m_mode[lri_pkg::MODE_UPPER]) begin
         lim = 64'(m_upper) <<< 16;
         if (m_acc > lim) m_acc = lim;
      end
      el = 57'(m_elapsed) + 57'(m_step);
      if (el > 57'(EMAX)) begin m_elapsed = EMAX; sat = 1; end
      else m_elapsed = el[55:0];
      if (m_mode[lri_pkg::MODE_AVG]) begin
         if (m_elapsed == 0) begin
            if (m_acc == 0) outv = 0;
            else begin sat = 1; outv = (m_acc < 0) ? VMIN : VMAX; end
         end else begin
            num = 128'(m_acc) <<< 8;
            quo = num / $signed({72'd0, m_elapsed});  // truncates toward zero
            if (quo > 128'(VMAX)) begin sat = 1; outv = VMAX; end
            else if (quo < 128'(VMIN)) begin sat = 1; outv = VMIN; end
            else outv = quo[63:0];
         end
      end else begin
         outv = clamp_value(m_acc >>> 16, sat);
      end
      if (m_mode[lri_pkg::MODE_SQRT]) begin
         if (outv < 0) outv = 0;
         else outv = clamp_value($signed(floor_sqrt(64'(outv) << 16)), sat);
      end
      sq = 128'(outv) * 128'(outv);
      if (sq > 128'(AMAX)) begin sat = 1; r.result_squared = {63{1'b1}}; end
      else r.result_squared = sq[62:0];
      r.result_value = outv[31:0];
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH word %0d %s: got %h expected %h", checked, what, got, want);
   endtask

   task automatic write_reg(logic [lri_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      // registers change only while no word is in flight
      while (expected_q.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lri_pkg::REG_GAIN:      m_gain = value;
         lri_pkg::REG_TIME_STEP: m_step = value;
         lri_pkg::REG_LOWER:     m_lower = value;
         lri_pkg::REG_UPPER:     m_upper = value;
         lri_pkg::REG_MODE:      m_mode = value[4:0];
         lri_pkg::REG_INITIAL: begin
            m_init = value;
            m_acc = 64'(m_init) <<< 16;
            m_elapsed = 0;
         end
         default: ;
      endcase
   endtask

   task automatic drain;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_word(lri_pkg::req_word_type w);
      if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      @(posedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      expected_q.push_back(integrate_tick(w));
      sent++;
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 131072) - 32'd65536;
         3: return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   function automatic lri_pkg::req_word_type rand_word(int restart_pct);
      lri_pkg::req_word_type w;
      w.sample_plus = ($urandom_range(0, 3) == 0) ? rand_value()
                    : $urandom_range(0, 262144) - 32'd131072;
      w.sample_minus = ($urandom_range(0, 3) == 0) ? rand_value()
                     : $urandom_range(0, 262144) - 32'd131072;
      w.sample_extra = ($urandom_range(0, 3) == 0) ? rand_value()
                     : $urandom_range(0, 65536) - 32'd32768;
      w.restart = ($urandom_range(0, 99) < restart_pct);
      w.restart_value = rand_value();
      return w;
   endfunction

   function automatic lri_pkg::req_word_type mk(logic [31:0] p, logic [31:0] m,
         logic [31:0] e, logic rs, logic [31:0] rv);
      lri_pkg::req_word_type w;
      w.sample_plus = p; w.sample_minus = m; w.sample_extra = e;
      w.restart = rs; w.restart_value = rv;
      return w;
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      lri_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0)
            report_mismatch("unexpected word", 64'(rsp_data.result_value), 64'd0);
         else begin
            want = expected_q.pop_front();
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", 64'(rsp_data.result_value),
                               64'(want.result_value));
            if (rsp_data.result_squared !== want.result_squared)
               report_mismatch("result_squared", 64'(rsp_data.result_squared),
                               64'(want.result_squared));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", 64'(rsp_data.saturated), 64'(want.saturated));
            n_sat += int'(rsp_data.saturated);
         end
         checked++;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_reset_defaults;
      send_word(mk(32'h10000, 32'd0, 32'd0, 1'b0, 32'd0));
      send_word(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, 32'd0));
      send_word(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1, 32'h80000000));
      drain();
   endtask

   task automatic test_modes;
      write_reg(lri_pkg::REG_LOWER, 32'hffff0000);
      write_reg(lri_pkg::REG_UPPER, 32'h00030000);
      for (int m = 0; m < 32; m++) begin
         write_reg(lri_pkg::REG_MODE, 32'(m));
         send_word(mk(32'h20000, 32'h8000, 32'h1000, m[0], 32'h4000));
         send_word(mk(32'h80000000, 32'd0, 32'd0, 1'b0, 32'd0));
         drain();
      end
   endtask

   task automatic test_special_cases;
      // lower above upper: upper wins
      write_reg(lri_pkg::REG_LOWER, 32'h00050000);
      write_reg(lri_pkg::REG_UPPER, 32'h00010000);
      write_reg(lri_pkg::REG_MODE, 32'd3);
      send_word(mk(32'h10000, 32'd0, 32'd0, 1'b0, 32'd0));
      // zero time step while averaging
      write_reg(lri_pkg::REG_TIME_STEP, 32'd0);
      write_reg(lri_pkg::REG_MODE, 32'd4);
      write_reg(lri_pkg::REG_INITIAL, 32'd0);
      send_word(mk(32'd0, 32'd0, 32'd0, 1'b0, 32'd0));
      send_word(mk(32'd0, 32'd0, 32'd0, 1'b1, 32'hfffe0000));
      send_word(mk(32'd0, 32'd0, 32'd0, 1'b1, 32'h00020000));
      // huge step and gain: samples, terms and outputs saturate, elapsed time and accumulator do not
      write_reg(lri_pkg::REG_TIME_STEP, 32'hffffffff);
      write_reg(lri_pkg::REG_GAIN, 32'h7fffffff);
      write_reg(lri_pkg::REG_MODE, 32'd8);
      repeat (4) send_word(mk(32'h7fffffff, 32'h80000000, 32'd0, 1'b0, 32'd0));
      write_reg(lri_pkg::REG_GAIN, 32'h80000000);
      write_reg(lri_pkg::REG_MODE, 32'd16);
      send_word(mk(32'h7fffffff, 32'd0, 32'd0, 1'b0, 32'd0));
      send_word(mk(32'd0, 32'd0, 32'd0, 1'b1, 32'h7fffffff));
      drain();
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 16; phase++) begin
         write_reg(lri_pkg::REG_GAIN, (phase % 4 == 0) ? rand_value()
                   : $urandom_range(0, 262144) - 32'd131072);
         write_reg(lri_pkg::REG_TIME_STEP, (phase == 3) ? 32'd1 : (phase == 5) ? 32'hffffffff
                   : $urandom_range(1, 1 << 25));
         write_reg(lri_pkg::REG_LOWER, rand_value());
         write_reg(lri_pkg::REG_UPPER, rand_value());
         write_reg(lri_pkg::REG_MODE, $urandom_range(0, 31));
         write_reg(lri_pkg::REG_INITIAL, rand_value());
         if (phase >= 13) quiet = 1;
         repeat (50) send_word(rand_word(10));
         drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_modes();
      test_special_cases();
      test_random();
      $display("Covered %0d words over all 32 mode settings, clamps, restarts and saturation",
               sent);
      $display("Checked %0d results, %0d with the saturated flag", checked, n_sat);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("limited_resettable_integrator_top test passed");
      end else begin
         $display("limited_resettable_integrator_top test failed");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("limited_resettable_integrator_top test failed");
      $finish;
   end
endmodule

[limited_resettable_integrator_top.f]
hw/rtl/lri_pkg.sv
hw/rtl/lri_smul.sv
hw/rtl/lri_sdiv.sv
hw/rtl/limited_resettable_integrator_top.sv
tb/tb_limited_resettable_integrator_top.sv
